>>> rtl/mpq_dual_name_hash_matcher_unit_macros.svh
// Assertion macros shared by the name hash matcher RTL.
`ifndef MPQ_DUAL_NAME_HASH_MATCHER_UNIT_MACROS_SVH
`define MPQ_DUAL_NAME_HASH_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPQH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpqh same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPQH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpqh next-cycle check failed");

`endif

>>> rtl/mpqh_pkg.sv
// Types, constants and crypt tables of the name hash matcher.
package mpqh_pkg;

   // Crypt table seed recurrence
   localparam logic [31:0] SEED_START = 32'h0010_0001;
   localparam logic [31:0] SEED_MUL   = 32'd125;
   localparam logic [31:0] SEED_MOD   = 32'h002A_AAAB;
   localparam logic [31:0] HALF_MASK  = 32'h0000_FFFF;
   localparam int unsigned CRYPT_DEPTH = 256;
   localparam int unsigned CRYPT_ROWS  = 5;

   // Reset values of the prefix words
   localparam logic [31:0] RESET_RESULT = 32'h7FED_7FED;
   localparam logic [31:0] RESET_ADJUST = 32'hEEEE_EEEE;
   localparam logic [31:0] RESET_TARGET = 32'h0000_0000;

   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PREFIX_RESULT_A = 3'd0,
      CSR_PREFIX_ADJUST_A = 3'd1,
      CSR_PREFIX_RESULT_B = 3'd2,
      CSR_PREFIX_ADJUST_B = 3'd3,
      CSR_TARGET_A        = 3'd4,
      CSR_TARGET_B        = 3'd5
   } csr_index_type;

   typedef logic [31:0] crypt_row_type [CRYPT_DEPTH];

   // One running hash: result word and adjust word
   typedef struct packed {
      logic [31:0] result;
      logic [31:0] adjust;
   } hash_state_type;

   // Stored configuration
   typedef struct packed {
      hash_state_type prefix_a;
      hash_state_type prefix_b;
      logic [31:0]    target_a;
      logic [31:0]    target_b;
   } csr_regs_type;

   // Prefix word loads caused by a configuration transfer
   typedef struct packed {
      logic        load_result_a;
      logic        load_adjust_a;
      logic        load_result_b;
      logic        load_adjust_b;
      logic [31:0] value;
   } csr_load_type;

   // Build one row of the crypt table at elaboration
   function automatic crypt_row_type build_crypt_row(input int unsigned row);
      crypt_row_type tbl;
      logic [31:0]   seed;
      logic [31:0]   hi;
      tbl  = '{default: '0};
      seed = SEED_START;
      for (int unsigned i = 0; i < CRYPT_DEPTH; i++) begin
         for (int unsigned r = 0; r < CRYPT_ROWS; r++) begin
            seed = (SEED_MUL * seed + 32'd3) % SEED_MOD;
            hi   = seed & HALF_MASK;
            seed = (SEED_MUL * seed + 32'd3) % SEED_MOD;
            if (r == row) begin
               tbl[i] = {hi[15:0], seed[15:0]};
            end
         end
      end
      return tbl;
   endfunction

   localparam crypt_row_type CRYPT_ROW_A = build_crypt_row(1);
   localparam crypt_row_type CRYPT_ROW_B = build_crypt_row(2);

endpackage

>>> rtl/mpqh_hash_step.sv
// One byte step of an MPQ-style string hash.
module mpqh_hash_step (
   input  mpqh_pkg::hash_state_type state_cur,
   input  logic [7:0]               char_byte,
   input  logic [31:0]              crypt_word,
   output mpqh_pkg::hash_state_type state_next
);

   logic [31:0] mixed;

   // Mix the table word into the running result
   assign mixed = (state_cur.result + state_cur.adjust) ^ crypt_word;

   // Advance result and adjust words, all mod 2^32
   assign state_next.result = mixed;
   assign state_next.adjust = state_cur.adjust + {24'd0, char_byte} + mixed
                            + {state_cur.adjust[26:0], 5'd0} + 32'd3;

endmodule

>>> rtl/mpqh_csr.sv
// Configuration registers of the name hash matcher.
module mpqh_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   output mpqh_pkg::csr_regs_type   regs,
   output mpqh_pkg::csr_load_type   load
);

   mpqh_pkg::csr_regs_type regs_ff;
   mpqh_pkg::csr_regs_type regs_in;

   // Decode the transfer into register writes and prefix loads
   always_comb begin
      regs_in            = regs_ff;
      load.load_result_a = 1'b0;
      load.load_adjust_a = 1'b0;
      load.load_result_b = 1'b0;
      load.load_adjust_b = 1'b0;
      load.value         = csr_wdata;
      if (csr_valid) begin
         case (mpqh_pkg::csr_index_type'(csr_index))
            mpqh_pkg::CSR_PREFIX_RESULT_A: begin
               regs_in.prefix_a.result = csr_wdata;
               load.load_result_a      = 1'b1;
            end
            mpqh_pkg::CSR_PREFIX_ADJUST_A: begin
               regs_in.prefix_a.adjust = csr_wdata;
               load.load_adjust_a      = 1'b1;
            end
            mpqh_pkg::CSR_PREFIX_RESULT_B: begin
               regs_in.prefix_b.result = csr_wdata;
               load.load_result_b      = 1'b1;
            end
            mpqh_pkg::CSR_PREFIX_ADJUST_B: begin
               regs_in.prefix_b.adjust = csr_wdata;
               load.load_adjust_b      = 1'b1;
            end
            mpqh_pkg::CSR_TARGET_A: begin
               regs_in.target_a = csr_wdata;
            end
            mpqh_pkg::CSR_TARGET_B: begin
               regs_in.target_b = csr_wdata;
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // Hold the configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.prefix_a.result <= mpqh_pkg::RESET_RESULT;
         regs_ff.prefix_a.adjust <= mpqh_pkg::RESET_ADJUST;
         regs_ff.prefix_b.result <= mpqh_pkg::RESET_RESULT;
         regs_ff.prefix_b.adjust <= mpqh_pkg::RESET_ADJUST;
         regs_ff.target_a        <= mpqh_pkg::RESET_TARGET;
         regs_ff.target_b        <= mpqh_pkg::RESET_TARGET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

>>> rtl/mpq_dual_name_hash_matcher_unit.sv
// Hashes a streamed file name with two MPQ-style hashes and one byte per
// cycle; a byte is registered on input, both hash words advance in the next
// cycle, and the final byte of a name loads a result register, so a result
// passes the input and then the result register. Throughput is one byte per
// cycle, set by the combinational running-word update (table lookup, add,
// xor and a five-term add); bytes keep flowing while a result waits unless
// another final byte needs the result register. The configuration port is
// always ready; a prefix word write also reloads the running word.
module mpq_dual_name_hash_matcher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] hash_a, [63:32] hash_b
   output logic        rsp_tuser,   // found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   mpqh_pkg::csr_regs_type   regs;
   mpqh_pkg::csr_load_type   load;
   mpqh_pkg::hash_state_type run_a_ff, run_a_in, step_a;
   mpqh_pkg::hash_state_type run_b_ff, run_b_in, step_b;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_last_ff, in_last_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_hash_a_ff, out_hash_a_in;
   logic [31:0] out_hash_b_ff, out_hash_b_in;
   logic        out_found_ff, out_found_in;
   logic        stage_move;
   logic [31:0] crypt_a;
   logic [31:0] crypt_b;

   assign csr_ready = 1'b1;

   mpqh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs),
      .load      (load)
   );

   // Look up both crypt rows
   assign crypt_a = mpqh_pkg::CRYPT_ROW_A[in_byte_ff];
   assign crypt_b = mpqh_pkg::CRYPT_ROW_B[in_byte_ff];

   mpqh_hash_step u_step_a (
      .state_cur  (run_a_ff),
      .char_byte  (in_byte_ff),
      .crypt_word (crypt_a),
      .state_next (step_a)
   );

   mpqh_hash_step u_step_b (
      .state_cur  (run_b_ff),
      .char_byte  (in_byte_ff),
      .crypt_word (crypt_b),
      .state_next (step_b)
   );

   // Advance the held byte unless a final byte finds the result slot full and untaken
   assign stage_move = in_valid_ff & (~in_last_ff | ~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | stage_move;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   // Running words: step, reload after a final byte, then prefix writes
   always_comb begin
      run_a_in = run_a_ff;
      run_b_in = run_b_ff;
      if (stage_move) begin
         run_a_in = in_last_ff ? regs.prefix_a : step_a;
         run_b_in = in_last_ff ? regs.prefix_b : step_b;
      end
      if (load.load_result_a) begin
         run_a_in.result = load.value;
      end
      if (load.load_adjust_a) begin
         run_a_in.adjust = load.value;
      end
      if (load.load_result_b) begin
         run_b_in.result = load.value;
      end
      if (load.load_adjust_b) begin
         run_b_in.adjust = load.value;
      end
   end

   // Result register: load on a final byte, drop on transfer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_hash_a_in = out_hash_a_ff;
      out_hash_b_in = out_hash_b_ff;
      out_found_in  = out_found_ff;
      if (stage_move && in_last_ff) begin
         out_valid_in  = 1'b1;
         out_hash_a_in = step_a.result;
         out_hash_b_in = step_b.result;
         out_found_in  = (step_a.result == regs.target_a)
                       & (step_b.result == regs.target_b);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         run_a_ff.result <= mpqh_pkg::RESET_RESULT;
         run_a_ff.adjust <= mpqh_pkg::RESET_ADJUST;
         run_b_ff.result <= mpqh_pkg::RESET_RESULT;
         run_b_ff.adjust <= mpqh_pkg::RESET_ADJUST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         run_a_ff     <= run_a_in;
         run_b_ff     <= run_b_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_last_ff    <= in_last_in;
      out_hash_a_ff <= out_hash_a_in;
      out_hash_b_ff <= out_hash_b_in;
      out_found_ff  <= out_found_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_hash_b_ff, out_hash_a_ff};
   assign rsp_tuser  = out_found_ff;

`include "mpq_dual_name_hash_matcher_unit_macros.svh"

   // A final byte that advances always leaves a result behind
   `MPQH_ASSERT_NEXT(a_last_gives_result, clock, reset,
      stage_move && in_last_ff, rsp_tvalid)

   // Bytes that are not final leave a waiting result untouched
   `MPQH_ASSERT_NEXT(a_mid_byte_keeps_result, clock, reset,
      stage_move && !in_last_ff && rsp_tvalid && !rsp_tready,
      $stable(rsp_tdata) && $stable(rsp_tuser))

   // After a final byte the running words equal the prefix words
   `MPQH_ASSERT_NEXT(a_reload_prefix, clock, reset,
      stage_move && in_last_ff && !csr_valid,
      run_a_ff == regs.prefix_a && run_b_ff == regs.prefix_b)

   // A held final byte stalls only on a full, untaken result register
   `MPQH_ASSERT_SAME(a_stall_reason, clock, reset,
      in_valid_ff && !stage_move,
      in_last_ff && rsp_tvalid && !rsp_tready)

endmodule
